>>> hdl/bezier_patch_evaluator_assert.svh
// Assertion helpers for the patch evaluator checks.
`ifndef BEZIER_PATCH_EVALUATOR_ASSERT_SVH
`define BEZIER_PATCH_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bezier patch evaluator check failed");

// Next-cycle implication, disabled during reset.
`define BPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bezier patch evaluator check failed");

`endif

>>> hdl/bpe_pkg.sv
`default_nettype none
package bpe_pkg;

  localparam int IDX_W  = 5;
  localparam int ADDR_W = 10;
  localparam int PARAM_W = 17;

  localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [1:0] REG_POINTS_PER_ROW = 2'd0;
  localparam logic [1:0] REG_ROWS_IN_USE    = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_LWAIT,
    S_MUL,
    S_ADD,
    S_DROP,
    S_ROW,
    S_DONE
  } bpe_state_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [IDX_W-1:0]   rd_col;
    logic               mul_en;
    logic               sel_row;
    logic [PARAM_W-1:0] t;
    logic               add_en;
    logic               drop_en;
    logic [IDX_W-1:0]   pos;
    logic               row_en;
    logic [IDX_W-1:0]   row_pos;
  } bpe_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/bpe_seq.sv
`default_nettype none
module bpe_seq import bpe_pkg::*; #(
  parameter int MAX_ROW_POINTS = 8,
  parameter int MAX_ROWS       = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               operation,
  input  wire logic [2:0]         row_index,
  input  wire logic [2:0]         column_index,
  input  wire logic [PARAM_W-1:0] param_u,
  input  wire logic [PARAM_W-1:0] param_v,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data,
  output logic                    busy,
  output logic                    done_en,
  output bpe_ctrl_t               ctrl
);

  localparam int NPW = $clog2(MAX_ROW_POINTS + 1);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int MW  = (NPW > NRW) ? NPW : NRW;
  localparam int CB  = $clog2(MAX_ROW_POINTS);
  localparam int RB  = $clog2(MAX_ROWS);

  bpe_state_t state, state_next;
  logic [3:0] points_per_row, rows_in_use;
  logic [NPW-1:0] np, c, c_next;
  logic [NRW-1:0] nr, r, r_next;
  logic [MW-1:0] m, m_next, j, j_next;
  logic vph, vph_next;
  logic [PARAM_W-1:0] pu, pv;
  logic accept, in_grid;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign in_grid = (int'(row_index) < MAX_ROWS) && (int'(column_index) < MAX_ROW_POINTS);

  always_comb begin
    if (points_per_row == 4'd0) begin
      np = NPW'(1);
    end else if (int'(points_per_row) > MAX_ROW_POINTS) begin
      np = NPW'(MAX_ROW_POINTS);
    end else begin
      np = NPW'(points_per_row);
    end
    if (rows_in_use == 4'd0) begin
      nr = NRW'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_per_row <= 4'd4;
      rows_in_use    <= 4'd4;
    end else if (cfg_valid) begin
      if (cfg_index == REG_POINTS_PER_ROW) begin
        points_per_row <= cfg_data;
      end else if (cfg_index == REG_ROWS_IN_USE) begin
        rows_in_use <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && operation == OP_EVAL) begin
      pu <= (param_u > ONE_Q16) ? ONE_Q16 : param_u;
      pv <= (param_v > ONE_Q16) ? ONE_Q16 : param_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
      c     <= '0;
      m     <= '0;
      j     <= '0;
      vph   <= 1'b0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      m     <= m_next;
      j     <= j_next;
      vph   <= vph_next;
    end
  end

  always_comb begin
    state_next = state;
    r_next = r;
    c_next = c;
    m_next = m;
    j_next = j;
    vph_next = vph;
    done_en = 1'b0;
    ctrl = '0;
    ctrl.wr_en = accept && (operation == OP_WRITE) && in_grid;
    ctrl.wr_addr = ADDR_W'({RB'(row_index), CB'(column_index)});
    ctrl.rd_addr = ADDR_W'({RB'(r), CB'(c)});
    ctrl.rd_col = IDX_W'(c);
    ctrl.sel_row = vph;
    ctrl.t = vph ? pv : pu;
    ctrl.pos = IDX_W'(m - MW'(1));
    ctrl.row_pos = IDX_W'(r);
    unique case (state)
      S_IDLE: begin
        if (accept && operation == OP_EVAL) begin
          state_next = S_LOAD;
          r_next = '0;
          c_next = '0;
          vph_next = 1'b0;
        end
      end
      S_LOAD: begin
        ctrl.rd_en = 1'b1;
        c_next = c + NPW'(1);
        if (c == np - NPW'(1)) begin
          state_next = S_LWAIT;
        end
      end
      S_LWAIT: begin
        m_next = MW'(np);
        j_next = '0;
        state_next = (np == NPW'(1)) ? S_ROW : S_MUL;
      end
      S_MUL: begin
        ctrl.mul_en = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        ctrl.add_en = 1'b1;
        j_next = j + MW'(1);
        state_next = (j == m - MW'(2)) ? S_DROP : S_MUL;
      end
      S_DROP: begin
        ctrl.drop_en = 1'b1;
        m_next = m - MW'(1);
        j_next = '0;
        if (m == MW'(2)) begin
          state_next = vph ? S_DONE : S_ROW;
        end else begin
          state_next = S_MUL;
        end
      end
      S_ROW: begin
        ctrl.row_en = 1'b1;
        r_next = r + NRW'(1);
        c_next = '0;
        if (r == nr - NRW'(1)) begin
          vph_next = 1'b1;
          m_next = MW'(nr);
          j_next = '0;
          state_next = (nr == NRW'(1)) ? S_DONE : S_MUL;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_DONE: begin
        done_en = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/bpe_lane.sv
`default_nettype none
module bpe_lane import bpe_pkg::*; #(
  parameter int MAX_ROW_POINTS = 8,
  parameter int MAX_ROWS       = 8,
  parameter int COORD_BITS     = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bpe_ctrl_t             ctrl,
  input  wire logic [31:0]           wr_data,
  output logic signed [COORD_BITS-1:0] result
);

  localparam int W  = COORD_BITS;
  localparam int AW = $clog2(MAX_ROWS) + $clog2(MAX_ROW_POINTS);
  localparam int PW = $clog2(MAX_ROW_POINTS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int PRW = W + 1 + PARAM_W + 1;

  logic signed [W-1:0] mem [1 << AW];
  logic signed [W-1:0] sp [MAX_ROW_POINTS];
  logic signed [W-1:0] rp [MAX_ROWS];
  logic signed [W-1:0] wdat, rd_q, a, b, res;
  logic signed [W:0] diff;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-17:0] step;
  logic signed [W+1:0] sum;
  logic ld_v;
  logic [IDX_W-1:0] ld_col;

  generate
    if (W > 32) begin : g_wide
      assign wdat = {{(W-32){wr_data[31]}}, wr_data};
    end else begin : g_narrow
      assign wdat = wr_data[W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr[AW-1:0]] <= wdat;
    end
    if (ctrl.rd_en) begin
      rd_q <= mem[ctrl.rd_addr[AW-1:0]];
    end
    ld_col <= ctrl.rd_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v <= 1'b0;
    end else begin
      ld_v <= ctrl.rd_en;
    end
  end

  assign a = ctrl.sel_row ? rp[0] : sp[0];
  assign b = ctrl.sel_row ? rp[1] : sp[1];
  assign diff = (W+1)'(b) - (W+1)'(a);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PRW'(diff) * PRW'($signed({1'b0, ctrl.t}));
    end
  end

  assign step = prod[PRW-1:16];
  assign sum = (W+2)'(a) + (W+2)'(step);
  assign res = sum[W-1:0];

  always_ff @(posedge clk) begin
    if (!ctrl.sel_row && (ctrl.add_en || ctrl.drop_en)) begin
      for (int i = 0; i < MAX_ROW_POINTS - 1; i++) begin
        if (ctrl.add_en && ctrl.pos[PW-1:0] == PW'(i)) begin
          sp[i] <= res;
        end else begin
          sp[i] <= sp[i+1];
        end
      end
      if (ctrl.add_en && ctrl.pos[PW-1:0] == PW'(MAX_ROW_POINTS - 1)) begin
        sp[MAX_ROW_POINTS-1] <= res;
      end
    end
    if (ld_v) begin
      sp[ld_col[PW-1:0]] <= rd_q;
    end
    if (ctrl.sel_row && (ctrl.add_en || ctrl.drop_en)) begin
      for (int i = 0; i < MAX_ROWS - 1; i++) begin
        if (ctrl.add_en && ctrl.pos[RW-1:0] == RW'(i)) begin
          rp[i] <= res;
        end else begin
          rp[i] <= rp[i+1];
        end
      end
      if (ctrl.add_en && ctrl.pos[RW-1:0] == RW'(MAX_ROWS - 1)) begin
        rp[MAX_ROWS-1] <= res;
      end
    end
    if (ctrl.row_en) begin
      rp[ctrl.row_pos[RW-1:0]] <= sp[0];
    end
  end

  assign result = rp[0];

endmodule
`default_nettype wire

>>> hdl/bpe_merge.sv
`default_nettype none
module bpe_merge #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  done_en,
  input  wire logic [COORD_BITS-1:0] lane_x,
  input  wire logic [COORD_BITS-1:0] lane_y,
  input  wire logic [COORD_BITS-1:0] lane_z,
  output logic                       done,
  output logic [31:0]                surface_x,
  output logic [31:0]                surface_y,
  output logic [31:0]                surface_z
);

  logic [31:0] ext_x, ext_y, ext_z;

  generate
    if (COORD_BITS >= 32) begin : g_trunc
      assign ext_x = lane_x[31:0];
      assign ext_y = lane_y[31:0];
      assign ext_z = lane_z[31:0];
    end else begin : g_sext
      assign ext_x = {{(32-COORD_BITS){lane_x[COORD_BITS-1]}}, lane_x};
      assign ext_y = {{(32-COORD_BITS){lane_y[COORD_BITS-1]}}, lane_y};
      assign ext_z = {{(32-COORD_BITS){lane_z[COORD_BITS-1]}}, lane_z};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_en;
    end
  end

  always_ff @(posedge clk) begin
    if (done_en) begin
      surface_x <= ext_x;
      surface_y <= ext_y;
      surface_z <= ext_z;
    end
  end

endmodule
`default_nettype wire

>>> hdl/bezier_patch_evaluator.sv
// Control point write: taken while idle, busy stays low.
// Evaluation: busy while each row is loaded and reduced with u, then the row
// results are reduced with v, using one shared lerp per lane; done pulses in
// the first cycle with busy low. One item at a time; results cannot be stalled.
// Reset: synchronous, returns to idle and sets both counts to 4; grid is not cleared.
`default_nettype none
module bezier_patch_evaluator import bpe_pkg::*; #(
  parameter int MAX_ROW_POINTS = 8,
  parameter int MAX_ROWS       = 8,
  parameter int COORD_BITS     = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation,
  input  wire logic [2:0]         row_index,
  input  wire logic [2:0]         column_index,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic [16:0]        param_u,
  input  wire logic [16:0]        param_v,
  output logic                    done,
  output logic signed [31:0]      surface_x,
  output logic signed [31:0]      surface_y,
  output logic signed [31:0]      surface_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data
);

  bpe_ctrl_t ctrl;
  logic done_en;
  logic [COORD_BITS-1:0] lane_x, lane_y, lane_z;

  assign cfg_ready = 1'b1;

  bpe_seq #(
    .MAX_ROW_POINTS(MAX_ROW_POINTS),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .row_index(row_index), .column_index(column_index),
    .param_u(param_u), .param_v(param_v),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .busy(busy), .done_en(done_en), .ctrl(ctrl)
  );

  bpe_lane #(
    .MAX_ROW_POINTS(MAX_ROW_POINTS), .MAX_ROWS(MAX_ROWS), .COORD_BITS(COORD_BITS)
  ) u_lane_x (
    .clk(clk), .rst(rst), .ctrl(ctrl), .wr_data(point_x), .result(lane_x)
  );

  bpe_lane #(
    .MAX_ROW_POINTS(MAX_ROW_POINTS), .MAX_ROWS(MAX_ROWS), .COORD_BITS(COORD_BITS)
  ) u_lane_y (
    .clk(clk), .rst(rst), .ctrl(ctrl), .wr_data(point_y), .result(lane_y)
  );

  bpe_lane #(
    .MAX_ROW_POINTS(MAX_ROW_POINTS), .MAX_ROWS(MAX_ROWS), .COORD_BITS(COORD_BITS)
  ) u_lane_z (
    .clk(clk), .rst(rst), .ctrl(ctrl), .wr_data(point_z), .result(lane_z)
  );

  bpe_merge #(
    .COORD_BITS(COORD_BITS)
  ) u_merge (
    .clk(clk), .rst(rst), .done_en(done_en),
    .lane_x(lane_x), .lane_y(lane_y), .lane_z(lane_z),
    .done(done), .surface_x(surface_x), .surface_y(surface_y), .surface_z(surface_z)
  );

endmodule
`default_nettype wire

>>> hdl/bpe_checker.sv
`default_nettype none
`include "bezier_patch_evaluator_assert.svh"
module bpe_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic operation,
  input wire logic done
);

  `BPE_ASSERT_NEXT(a_done_single, done, !done)
  `BPE_ASSERT_NOW(a_done_idle, done, !busy)
  `BPE_ASSERT_NEXT(a_eval_busy, start && !busy && operation, busy)
  `BPE_ASSERT_NEXT(a_write_quiet, start && !busy && !operation, !busy && !done)

endmodule

bind bezier_patch_evaluator bpe_checker u_bpe_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .operation(operation), .done(done)
);
`default_nettype wire

>>> dv/bezier_patch_evaluator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module bezier_patch_evaluator_tb;
  import bpe_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  class patch_scoreboard;
    point_t grid[8][8];
    logic [3:0] np_reg;
    logic [3:0] nr_reg;
    point_t pending[$];
    int     errors;

    function new();
      np_reg = 4'd4;
      nr_reg = 4'd4;
      errors = 0;
    endfunction

    function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                                 logic [16:0] t);
      logic signed [63:0] s;
      s = 64'(a) * $signed(64'(17'h10000 - t)) + 64'(b) * $signed({47'd0, t});
      return 32'(s >>> 16);
    endfunction

    function automatic point_t blend_pt(point_t a, point_t b, logic [16:0] t);
      point_t r;
      r.x = blend(a.x, b.x, t);
      r.y = blend(a.y, b.y, t);
      r.z = blend(a.z, b.z, t);
      return r;
    endfunction

    function automatic int eff_count(logic [3:0] v);
      if (v == 0) return 1;
      if (v > 8) return 8;
      return v;
    endfunction

    function automatic void note_beat(logic op, logic [2:0] ri, logic [2:0] ci,
                                      point_t p, logic [16:0] pu, logic [16:0] pv);
      point_t rows[8];
      point_t work[8];
      int np, nr;
      logic [16:0] u, v;
      if (op == OP_WRITE) begin
        grid[ri][ci] = p;
        return;
      end
      np = eff_count(np_reg);
      nr = eff_count(nr_reg);
      u = (pu > ONE_Q16) ? ONE_Q16 : pu;
      v = (pv > ONE_Q16) ? ONE_Q16 : pv;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < np; c++) work[c] = grid[r][c];
        for (int l = 1; l < np; l++)
          for (int k = 0; k + l < np; k++) work[k] = blend_pt(work[k], work[k+1], u);
        rows[r] = work[0];
      end
      for (int l = 1; l < nr; l++)
        for (int k = 0; k + l < nr; k++) rows[k] = blend_pt(rows[k], rows[k+1], v);
      pending = {pending, rows[0]};
    endfunction

    function automatic void check_beat(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z);
      point_t e;
      if (pending.size() == 0) begin
        $error("unexpected result x=%h y=%h z=%h", x, y, z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin $error("surface_x exp %h got %h", e.x, x); errors++; end
      if (y !== e.y) begin $error("surface_y exp %h got %h", e.y, y); errors++; end
      if (z !== e.z) begin $error("surface_z exp %h got %h", e.z, z); errors++; end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic start = 0, operation = 0;
  logic [2:0] row_index = 0, column_index = 0;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
  logic [16:0] param_u = 0, param_v = 0;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = 0;
  logic [3:0] cfg_data = 0;
  wire busy, done, cfg_ready;
  wire signed [31:0] surface_x, surface_y, surface_z;

  patch_scoreboard board;
  int idle_pct;
  longint cycles;

  bezier_patch_evaluator dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("bezier_patch_evaluator verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done) board.check_beat(surface_x, surface_y, surface_z);

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONE_Q16;
      2: return 17'($urandom_range(ONE_Q16 + 1, 17'h1ffff));
      default: return 17'($urandom_range(0, ONE_Q16));
    endcase
  endfunction

  task automatic send_item(logic op, logic [2:0] ri, logic [2:0] ci, point_t p,
                           logic [16:0] pu, logic [16:0] pv);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    operation <= op;
    row_index <= ri;
    column_index <= ci;
    point_x <= p.x;
    point_y <= p.y;
    point_z <= p.z;
    param_u <= pu;
    param_v <= pv;
    do @(posedge clk); while (busy);
    board.note_beat(op, ri, ci, p, pu, pv);
  endtask

  task automatic write_point(int r, int c);
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    send_item(OP_WRITE, 3'(r), 3'(c), p, 17'($urandom), 17'($urandom));
  endtask

  task automatic evaluate(logic [16:0] pu, logic [16:0] pv);
    point_t p;
    p.x = $urandom;
    p.y = $urandom;
    p.z = $urandom;
    send_item(OP_EVAL, 3'($urandom), 3'($urandom), p, pu, pv);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == REG_POINTS_PER_ROW) board.np_reg = val;
    else board.nr_reg = val;
    @(posedge clk);
  endtask

  task automatic fill_grid();
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) write_point(r, c);
  endtask

  initial begin
    logic [3:0] np_set[10] = '{1, 8, 0, 15, 2, 3, 8, 5, 1, 4};
    logic [3:0] nr_set[10] = '{8, 1, 15, 0, 2, 8, 3, 6, 1, 4};
    board = new();
    cycles = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    fill_grid();
    evaluate(0, 0);
    evaluate(ONE_Q16, ONE_Q16);
    evaluate(17'h1ffff, 17'h10001);
    evaluate(17'h08000, 17'h04000);
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 12;
        default: idle_pct = 0;
      endcase
      write_reg(REG_POINTS_PER_ROW, np_set[ph]);
      write_reg(REG_ROWS_IN_USE, nr_set[ph]);
      for (int i = 0; i < 89; i++) begin
        if ($urandom_range(0, 2) == 0) evaluate(rand_param(), rand_param());
        else write_point($urandom_range(0, 7), $urandom_range(0, 7));
      end
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("bezier_patch_evaluator verification clean");
    else
      $display("bezier_patch_evaluator verification failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/bpe_pkg.sv
hdl/bpe_seq.sv
hdl/bpe_lane.sv
hdl/bpe_merge.sv
hdl/bezier_patch_evaluator.sv
hdl/bpe_checker.sv
dv/bezier_patch_evaluator_tb.sv
